// ===== src/hst_pkg.sv =====
// Shared constants, types and codes of the HSV tint core.
`timescale 1ns / 1ps
`default_nettype none
package hst_pkg;

	// Number formats
	localparam int FRAC_BITS     = 10;
	localparam int HUE_FRAC_BITS = 6;
	localparam int COMP_W        = 16;
	localparam int ALPHA_W       = 11;
	localparam int SHIFT_W       = 15;
	localparam int GAIN_W        = 12;
	localparam int CFG_IDX_W     = 2;

	localparam int ONE_GAIN   = 1 << FRAC_BITS;
	localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
	localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;
	localparam int HUE_W      = 15;
	localparam int T_W        = 12;
	localparam int SAT_W      = 17;
	localparam int SAT_ONE    = 1 << 16;
	localparam int VALUE_MAX  = 32 << FRAC_BITS;

	// Divider shapes
	localparam int DIV_QW = 17;
	localparam int HUE_NW = 29;
	localparam int SAT_NW = 34;
	localparam int DEN_W  = 17;

	// Reciprocal of 15 for the sector-size divide (3840 = 256 * 15)
	localparam int RECIP_15 = 559241;
	localparam int RECIP_SH = 23;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HUE_SHIFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VAL_GAIN  = 2'd2;

	typedef enum logic [1:0] {
		MAX_RED   = 2'd0,
		MAX_GREEN = 2'd1,
		MAX_BLUE  = 2'd2
	} max_sel_t;

	typedef logic [2:0] sector_t;

	// Pass-through part of a word
	typedef struct packed {
		logic [COMP_W-1:0]  red;
		logic [COMP_W-1:0]  green;
		logic [COMP_W-1:0]  blue;
		logic [ALPHA_W-1:0] alpha;
		logic               lock;
	} pass_t;

	// Data that rides beside the dividers
	typedef struct packed {
		pass_t             pass;
		logic [COMP_W-1:0] high;
		logic [COMP_W-1:0] span;
		logic              neg;
		max_sel_t          msel;
	} side_t;

endpackage
`default_nettype wire

// ===== src/hst_ifs.sv =====
// Channel interfaces of the HSV tint core: pixel in, pixel out, register write.
`timescale 1ns / 1ps
`default_nettype none
interface hst_pix_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] red_in;
	logic [15:0] green_in;
	logic [15:0] blue_in;
	logic [10:0] alpha_in;
	logic        lock_hue;
	modport source (output valid, red_in, green_in, blue_in, alpha_in, lock_hue, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, lock_hue, output ready);
endinterface

interface hst_pix_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic [10:0] alpha_out;
	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface hst_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [14:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/hst_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module hst_divider #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 17,
	parameter int QUO_W = 17
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);
	localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [NUM_W-1:0] rem_r [QUO_W];
	logic [DEN_W-1:0] den_r [QUO_W];
	logic [QUO_W-1:0] quo_r [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int B = QUO_W - 1 - i;
		logic [NUM_W-1:0] rem_in;
		logic [NUM_W-1:0] rem_nx;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [QUO_W-1:0] quo_nx;
		logic [W-1:0]     trial;

		// Pick the stage input
		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_r[i-1];
			assign den_in = den_r[i-1];
			assign quo_in = quo_r[i-1];
		end

		// Subtract the shifted divisor where it fits
		always_comb begin
			trial  = W'(den_in) << B;
			rem_nx = rem_in;
			quo_nx = quo_in;
			if (W'(rem_in) >= trial) begin
				rem_nx    = NUM_W'(W'(rem_in) - trial);
				quo_nx[B] = 1'b1;
			end
		end

		// Advance one stage
		always_ff @(posedge clk) begin
			if (en) begin
				rem_r[i] <= rem_nx;
				den_r[i] <= den_in;
				quo_r[i] <= quo_nx;
			end
		end
	end

	assign quo = quo_r[QUO_W-1];

endmodule
`default_nettype wire

// ===== src/hst_rgb_build.sv =====
// HSV to RGB back end: chroma, second component and sector placement over three stages.
`timescale 1ns / 1ps
`default_nettype none
module hst_rgb_build (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [hst_pkg::COMP_W-1:0] val,
	input  wire logic [hst_pkg::SAT_W-1:0]  sat,
	input  wire hst_pkg::sector_t           sector,
	input  wire logic [hst_pkg::T_W-1:0]    t,
	output logic      [hst_pkg::COMP_W-1:0] red,
	output logic      [hst_pkg::COMP_W-1:0] green,
	output logic      [hst_pkg::COMP_W-1:0] blue
);
	import hst_pkg::*;

	localparam int X_W = 27;
	localparam int Y_W = X_W - 8;
	localparam int P_W = Y_W + 20;

	logic [32:0]       chroma_full;
	logic [COMP_W-1:0] chroma_c;
	logic [COMP_W-1:0] chroma_s4, val_s4;
	sector_t           sec_s4;
	logic [T_W-1:0]    t_s4;
	logic [X_W-1:0]    x_s5;
	logic [COMP_W-1:0] chroma_s5, base_s5;
	sector_t           sec_s5;
	logic [Y_W-1:0]    y;
	logic [P_W-1:0]    prod;
	logic [COMP_W-1:0] second_s6, chroma_s6, base_s6;
	sector_t           sec_s6;
	logic [COMP_W-1:0] c0, c1, c2;

	// Chroma from value and saturation, rounded, never above value
	always_comb begin
		chroma_full = 33'(33'(val) * 33'(sat)) + 33'(SAT_ONE / 2);
		chroma_c    = (chroma_full[32:16] > 17'(val)) ? val : chroma_full[31:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chroma_s4 <= chroma_c;
			val_s4    <= val;
			sec_s4    <= sector;
			t_s4      <= t;
		end
	end

	// Product for the second component, with the rounding half added
	always_ff @(posedge clk) begin
		if (en) begin
			x_s5      <= X_W'(X_W'(chroma_s4) * X_W'(t_s4)) + X_W'(HUE_SECTOR / 2);
			chroma_s5 <= chroma_s4;
			base_s5   <= val_s4 - chroma_s4;
			sec_s5    <= sec_s4;
		end
	end

	// Divide by the sector size: drop 8 bits, then multiply by the reciprocal of 15
	always_comb begin
		y    = x_s5[X_W-1:8];
		prod = P_W'(P_W'(y) * P_W'(RECIP_15));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			second_s6 <= prod[RECIP_SH +: COMP_W];
			chroma_s6 <= chroma_s5;
			base_s6   <= base_s5;
			sec_s6    <= sec_s5;
		end
	end

	// Place chroma and second component by sector
	always_comb begin
		c0 = '0;
		c1 = '0;
		c2 = '0;
		case (sec_s6)
			3'd0: begin
				c0 = chroma_s6;
				c1 = second_s6;
			end
			3'd1: begin
				c0 = second_s6;
				c1 = chroma_s6;
			end
			3'd2: begin
				c1 = chroma_s6;
				c2 = second_s6;
			end
			3'd3: begin
				c1 = second_s6;
				c2 = chroma_s6;
			end
			3'd4: begin
				c0 = second_s6;
				c2 = chroma_s6;
			end
			default: begin
				c0 = chroma_s6;
				c2 = second_s6;
			end
		endcase
		red   = c0 + base_s6;
		green = c1 + base_s6;
		blue  = c2 + base_s6;
	end

endmodule
`default_nettype wire

// ===== src/hsv_hue_shift_tint_core.sv =====
// Top level of the HSV tint core: RGB to HSV, hue rotation, gains, HSV to RGB.
//
//  channel   dir  handshake     word
//  pix_in    in   valid/ready   red_in, green_in, blue_in, alpha_in, lock_hue
//  pix_out   out  valid/ready   red_out, green_out, blue_out, alpha_out
//  cfg       in   valid/ready   index, data (ready always high)
//
// One word enters per cycle while pix_out is not stalled; each word passes the two 17-stage dividers
// for hue offset and saturation plus seven surrounding register stages.
// arst_n clears the valid bits, the output valid and the tint registers.
// A stall at pix_out freezes every stage at once; pix_in.ready drops only then.
`timescale 1ns / 1ps
`default_nettype none
module hsv_hue_shift_tint_core (
	input  wire logic clk,
	input  wire logic arst_n,
	hst_pix_in_if.sink    pix_in,
	hst_pix_out_if.source pix_out,
	hst_cfg_if.sink       cfg
);
	import hst_pkg::*;

	logic signed [SHIFT_W-1:0] hue_shift_q;
	logic [GAIN_W-1:0]         sat_gain_q;
	logic [GAIN_W-1:0]         val_gain_q;

	logic en;

	// Front end
	logic [COMP_W-1:0]     hi_c, lo_c, span_c, mag_c;
	logic signed [COMP_W:0] delta_c;
	max_sel_t              msel_c;
	logic                  vld_s1;
	side_t                 side_s1;
	logic [HUE_NW-1:0]     hnum_s1;
	logic [SAT_NW-1:0]     snum_s1;

	// Divider side line
	logic                  vld_sd [DIV_QW];
	side_t                 side_sd [DIV_QW];
	logic [DIV_QW-1:0]     hq, sq;

	// Hue and saturation
	logic signed [17:0]    off_c, h0_c, h1_c;
	logic                  vld_s2;
	logic [HUE_W-1:0]      hue_s2;
	logic [SAT_W-1:0]      sat_s2;
	logic [COMP_W-1:0]     high_s2;
	pass_t                 pass_s2;

	// Gains and sector
	logic [29:0]           sat_p;
	logic [28:0]           val_p;
	logic [19:0]           sat_r;
	logic [18:0]           val_r;
	sector_t               sec_c;
	logic [HUE_W-1:0]      in_sec_c;
	logic                  vld_s3;
	logic [SAT_W-1:0]      sat_s3;
	logic [COMP_W-1:0]     val_s3;
	sector_t               sec_s3;
	logic [T_W-1:0]        t_s3;
	pass_t                 pass_s3;

	// Back end carry
	logic                  vld_s4, vld_s5, vld_s6;
	pass_t                 pass_s4, pass_s5, pass_s6;
	logic [COMP_W-1:0]     red_b, green_b, blue_b;
	logic                  unity, bypass;

	// Output register
	logic                  out_vld_q;
	logic [COMP_W-1:0]     out_red_q, out_green_q, out_blue_q;
	logic [ALPHA_W-1:0]    out_alpha_q;

	// Advance the whole pipe unless the output word is held
	assign en           = !out_vld_q || pix_out.ready;
	assign pix_in.ready = en;
	assign cfg.ready    = 1'b1;

	// Write tint registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q <= '0;
			sat_gain_q  <= GAIN_W'(ONE_GAIN);
			val_gain_q  <= GAIN_W'(ONE_GAIN);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_HUE_SHIFT: hue_shift_q <= $signed(cfg.data);
				CFG_SAT_GAIN:  sat_gain_q  <= cfg.data[GAIN_W-1:0];
				CFG_VAL_GAIN:  val_gain_q  <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Find max, min and the signed difference for the hue offset
	always_comb begin
		hi_c = (pix_in.red_in > pix_in.green_in) ? pix_in.red_in : pix_in.green_in;
		if (pix_in.blue_in > hi_c) hi_c = pix_in.blue_in;
		lo_c = (pix_in.red_in < pix_in.green_in) ? pix_in.red_in : pix_in.green_in;
		if (pix_in.blue_in < lo_c) lo_c = pix_in.blue_in;
		span_c = hi_c - lo_c;
		if (hi_c == pix_in.red_in) begin
			msel_c  = MAX_RED;
			delta_c = $signed({1'b0, pix_in.green_in}) - $signed({1'b0, pix_in.blue_in});
		end else if (hi_c == pix_in.green_in) begin
			msel_c  = MAX_GREEN;
			delta_c = $signed({1'b0, pix_in.blue_in}) - $signed({1'b0, pix_in.red_in});
		end else begin
			msel_c  = MAX_BLUE;
			delta_c = $signed({1'b0, pix_in.red_in}) - $signed({1'b0, pix_in.green_in});
		end
		mag_c = delta_c[COMP_W] ? COMP_W'(-delta_c) : delta_c[COMP_W-1:0];
	end

	// Register divider operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.pass.red   <= pix_in.red_in;
			side_s1.pass.green <= pix_in.green_in;
			side_s1.pass.blue  <= pix_in.blue_in;
			side_s1.pass.alpha <= pix_in.alpha_in;
			side_s1.pass.lock  <= pix_in.lock_hue;
			side_s1.high       <= hi_c;
			side_s1.span       <= span_c;
			side_s1.neg        <= delta_c[COMP_W];
			side_s1.msel       <= msel_c;
			hnum_s1 <= HUE_NW'({HUE_NW'(HUE_NW'(mag_c) * HUE_NW'(HUE_SECTOR)), 1'b0})
				+ HUE_NW'(span_c);
			snum_s1 <= {1'b0, span_c, 17'b0} + SAT_NW'(hi_c);
		end
	end

	hst_divider #(.NUM_W(HUE_NW), .DEN_W(DEN_W), .QUO_W(DIV_QW)) u_hue_div (
		.clk (clk),
		.en  (en),
		.num (hnum_s1),
		.den ({side_s1.span, 1'b0}),
		.quo (hq)
	);

	hst_divider #(.NUM_W(SAT_NW), .DEN_W(DEN_W), .QUO_W(DIV_QW)) u_sat_div (
		.clk (clk),
		.en  (en),
		.num (snum_s1),
		.den ({side_s1.high, 1'b0}),
		.quo (sq)
	);

	// Carry side data beside the divider stages
	for (genvar i = 0; i < DIV_QW; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i] <= 1'b0;
			end else if (en) begin
				vld_sd[i] <= (i == 0) ? vld_s1 : vld_sd[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_sd[i] <= (i == 0) ? side_s1 : side_sd[(i == 0) ? 0 : i-1];
			end
		end
	end

	// Build the hue, rotate it unless locked, wrap into one turn
	always_comb begin
		off_c = side_sd[DIV_QW-1].neg ? -$signed({6'b0, hq[T_W-1:0]})
			: $signed({6'b0, hq[T_W-1:0]});
		case (side_sd[DIV_QW-1].msel)
			MAX_RED: begin
				h0_c = off_c;
				if (h0_c < 0) h0_c = h0_c + $signed(18'(HUE_FULL));
			end
			MAX_GREEN: h0_c = $signed(18'(2 * HUE_SECTOR)) + off_c;
			default:   h0_c = $signed(18'(4 * HUE_SECTOR)) + off_c;
		endcase
		if (side_sd[DIV_QW-1].span == '0) h0_c = '0;
		h1_c = h0_c;
		if (!side_sd[DIV_QW-1].pass.lock) begin
			h1_c = h0_c + 18'(hue_shift_q);
			if (h1_c < 0) h1_c = h1_c + $signed(18'(HUE_FULL));
			else if (h1_c >= $signed(18'(HUE_FULL))) h1_c = h1_c - $signed(18'(HUE_FULL));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_sd[DIV_QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s2  <= h1_c[HUE_W-1:0];
			sat_s2  <= (side_sd[DIV_QW-1].high == '0) ? '0 : sq;
			high_s2 <= side_sd[DIV_QW-1].high;
			pass_s2 <= side_sd[DIV_QW-1].pass;
		end
	end

	// Apply gains with clamps, split hue into sector and offset
	always_comb begin
		sat_p = 30'(30'(sat_s2) * 30'(sat_gain_q)) + 30'(ONE_GAIN / 2);
		val_p = 29'(29'(high_s2) * 29'(val_gain_q)) + 29'(ONE_GAIN / 2);
		sat_r = sat_p[29:FRAC_BITS];
		val_r = val_p[28:FRAC_BITS];
		sec_c = '0;
		for (int k = 1; k < 6; k++) begin
			if (hue_s2 >= HUE_W'(k * HUE_SECTOR)) sec_c = 3'(k);
		end
		in_sec_c = hue_s2 - HUE_W'(HUE_W'(sec_c) * HUE_W'(HUE_SECTOR));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s3  <= (sat_r > 20'(SAT_ONE)) ? SAT_W'(SAT_ONE) : sat_r[SAT_W-1:0];
			val_s3  <= (val_r > 19'(VALUE_MAX)) ? COMP_W'(VALUE_MAX) : val_r[COMP_W-1:0];
			sec_s3  <= sec_c;
			t_s3    <= sec_c[0] ? T_W'(HUE_W'(HUE_SECTOR) - in_sec_c) : in_sec_c[T_W-1:0];
			pass_s3 <= pass_s2;
		end
	end

	hst_rgb_build u_rgb (
		.clk    (clk),
		.en     (en),
		.val    (val_s3),
		.sat    (sat_s3),
		.sector (sec_s3),
		.t      (t_s3),
		.red    (red_b),
		.green  (green_b),
		.blue   (blue_b)
	);

	// Carry the pass-through part beside the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s4 <= pass_s3;
			pass_s5 <= pass_s4;
			pass_s6 <= pass_s5;
		end
	end

	// Pass the colour through for a neutral tint or a locked word at unity gains
	assign unity  = (sat_gain_q == GAIN_W'(ONE_GAIN)) && (val_gain_q == GAIN_W'(ONE_GAIN));
	assign bypass = unity && ((hue_shift_q == '0) || pass_s6.lock);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_red_q   <= bypass ? pass_s6.red : red_b;
			out_green_q <= bypass ? pass_s6.green : green_b;
			out_blue_q  <= bypass ? pass_s6.blue : blue_b;
			out_alpha_q <= pass_s6.alpha;
		end
	end

	assign pix_out.valid     = out_vld_q;
	assign pix_out.red_out   = out_red_q;
	assign pix_out.green_out = out_green_q;
	assign pix_out.blue_out  = out_blue_q;
	assign pix_out.alpha_out = out_alpha_q;

	a_hue_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> hue_s2 < HUE_W'(HUE_FULL))
		else $error("hue left one turn after rotation");

	a_gain_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (sat_s3 <= SAT_W'(SAT_ONE)) && (val_s3 <= COMP_W'(VALUE_MAX)))
		else $error("scaled saturation or value above clamp");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (vld_s1 == $past(vld_s1)) && (vld_s6 == $past(vld_s6)))
		else $error("pipe moved during a stall");

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !pix_out.ready) |-> !pix_in.ready)
		else $error("input taken while output word held");

endmodule
`default_nettype wire

// ===== tb/sv/hst_tb_ifs_note.sv =====
// Shared testbench types for the HSV tint core bench.
`timescale 1ns / 1ps
package hst_tb_pkg;
	import hst_pkg::*;

	// One pixel word as offered on the input channel
	typedef struct packed {
		logic [COMP_W-1:0]  red;
		logic [COMP_W-1:0]  green;
		logic [COMP_W-1:0]  blue;
		logic [ALPHA_W-1:0] alpha;
		logic               lock;
	} pix_word_t;

	// One tinted pixel as returned on the output channel
	typedef struct packed {
		logic [COMP_W-1:0]  red;
		logic [COMP_W-1:0]  green;
		logic [COMP_W-1:0]  blue;
		logic [ALPHA_W-1:0] alpha;
	} tint_word_t;
endpackage

// ===== tb/sv/hsv_hue_shift_tint_core_tb.sv =====
// Testbench of the HSV tint core: random pixels and tint settings checked against a predictor.
`timescale 1ns / 1ps
module hsv_hue_shift_tint_core_tb;
	import hst_pkg::*;
	import hst_tb_pkg::*;

	localparam int LATENCY   = 24;
	localparam int IDLE_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hst_pix_in_if  pix_in ();
	hst_pix_out_if pix_out ();
	hst_cfg_if     cfg ();

	hsv_hue_shift_tint_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in.sink),
		.pix_out(pix_out.source),
		.cfg    (cfg.sink)
	);

	// Tint setting shadowed by the predictor
	logic signed [SHIFT_W-1:0] shift_q;
	logic [GAIN_W-1:0]         sat_gain_q;
	logic [GAIN_W-1:0]         val_gain_q;

	pix_word_t  pending_words[$];
	tint_word_t tinted_expect[$];
	int errors = 0;
	int words_sent = 0;
	int words_seen = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;
	int hold_off = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
		return (num * 2 + den) / (den * 2);
	endfunction

	function automatic longint signed hue_offset(longint signed delta, longint unsigned span);
		longint unsigned mag;
		longint signed q;
		mag = delta < 0 ? -delta : delta;
		q = rdiv(mag * HUE_SECTOR, span);
		return delta < 0 ? -q : q;
	endfunction

	// Compute the tinted color of one pixel under the current setting
	function automatic tint_word_t tint_pixel(pix_word_t w);
		tint_word_t o;
		longint unsigned r, g, b, hi, lo, span, sat, val, chroma, second, base, t;
		longint unsigned c0, c1, c2;
		longint signed hue, h, sector;
		bit unity;
		r = w.red; g = w.green; b = w.blue;
		unity = sat_gain_q == ONE_GAIN && val_gain_q == ONE_GAIN;
		o.alpha = w.alpha;
		if ((shift_q == 0 && unity) || (w.lock && unity)) begin
			o.red = w.red; o.green = w.green; o.blue = w.blue;
			return o;
		end
		hi = r > g ? r : g; if (b > hi) hi = b;
		lo = r < g ? r : g; if (b < lo) lo = b;
		span = hi - lo;
		hue = 0;
		if (span > 0) begin
			if (hi == r) begin
				hue = hue_offset(longint'(g) - longint'(b), span);
				if (hue < 0) hue += HUE_FULL;
			end else if (hi == g) begin
				hue = 2 * HUE_SECTOR + hue_offset(longint'(b) - longint'(r), span);
			end else begin
				hue = 4 * HUE_SECTOR + hue_offset(longint'(r) - longint'(g), span);
			end
		end
		sat = hi > 0 ? rdiv(span * SAT_ONE, hi) : 0;
		if (!w.lock) begin
			h = hue + longint'(shift_q) + 2 * HUE_FULL;
			if (h < 0) h = 0;
			hue = h % HUE_FULL;
		end
		sat = rdiv(sat * sat_gain_q, ONE_GAIN);
		if (sat > SAT_ONE) sat = SAT_ONE;
		val = rdiv(hi * val_gain_q, ONE_GAIN);
		if (val > VALUE_MAX) val = VALUE_MAX;
		chroma = rdiv(val * sat, SAT_ONE);
		if (chroma > val) chroma = val;
		sector = hue / HUE_SECTOR;
		t = hue % HUE_SECTOR;
		if (sector[0]) t = HUE_SECTOR - t;
		second = rdiv(chroma * t, HUE_SECTOR);
		c0 = 0; c1 = 0; c2 = 0;
		case (sector % 6)
			0: begin c0 = chroma; c1 = second; end
			1: begin c0 = second; c1 = chroma; end
			2: begin c1 = chroma; c2 = second; end
			3: begin c1 = second; c2 = chroma; end
			4: begin c0 = second; c2 = chroma; end
			default: begin c0 = chroma; c2 = second; end
		endcase
		base = val - chroma;
		o.red = COMP_W'(c0 + base);
		o.green = COMP_W'(c1 + base);
		o.blue = COMP_W'(c2 + base);
		return o;
	endfunction

	function automatic logic [COMP_W-1:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'd32768;
			2: return COMP_W'($urandom_range(32769, 65535));
			3: return COMP_W'($urandom_range(0, 40));
			default: return COMP_W'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic pix_word_t rand_pixel();
		pix_word_t w;
		logic [COMP_W-1:0] c;
		w.red = rand_comp(); w.green = rand_comp(); w.blue = rand_comp();
		// Force ties and grays now and then
		c = w.red;
		case ($urandom_range(0, 7))
			0: begin w.green = c; w.blue = c; end
			1: w.green = c;
			2: w.blue = w.green;
			default: ;
		endcase
		w.alpha = $urandom_range(0, 3) == 0 ? 11'($urandom) : 11'($urandom_range(0, 1024));
		w.lock = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// Drive the pixel input from the pending queue
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_in.valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (pix_in.valid && pix_in.ready) begin
				tinted_expect.insert(tinted_expect.size(),
					tint_pixel(pending_words.pop_front()));
				words_sent <= words_sent + 1;
			end
			if (pix_in.valid && !pix_in.ready) begin
				// hold the word
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				pix_in.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				pix_word_t w;
				w = pending_words[0];
				pix_in.valid <= 1'b1;
				{pix_in.red_in, pix_in.green_in, pix_in.blue_in, pix_in.alpha_in,
					pix_in.lock_hue} <= w;
				in_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
			end else begin
				pix_in.valid <= 1'b0;
			end
		end
	end

	// Check every output word against the oldest expectation
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out.ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				tint_word_t got, want;
				got = {pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.alpha_out};
				words_seen <= words_seen + 1;
				if (tinted_expect.size() == 0) begin
					$display("%0t: unexpected word %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = tinted_expect.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
							$time, want.red, want.green, want.blue, want.alpha,
							got.red, got.green, got.blue, got.alpha);
						errors <= errors + 1;
					end
				end
			end
			// Long hold-off first, then random stalls
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				pix_out.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				pix_out.ready <= 1'b0;
			end else begin
				pix_out.ready <= 1'b1;
				if (pix_out.valid && pix_out.ready)
					out_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || stim_done)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SHIFT_W-1:0] data);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_HUE_SHIFT) shift_q = data;
		else if (idx == CFG_SAT_GAIN) sat_gain_q = data[GAIN_W-1:0];
		else if (idx == CFG_VAL_GAIN) val_gain_q = data[GAIN_W-1:0];
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_words.size() > 0 || tinted_expect.size() > 0 || pix_in.valid)
				&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic push_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic [10:0] a, logic l);
		pending_words.insert(pending_words.size(), {r, g, b, a, l});
	endtask

	task automatic push_random(int n);
		repeat (n) pending_words.insert(pending_words.size(), rand_pixel());
	endtask

	initial begin
		int phase;
		cfg.valid = 1'b0;
		cfg.index = CFG_HUE_SHIFT;
		cfg.data = '0;
		pix_in.valid = 1'b0;
		pix_in.red_in = '0; pix_in.green_in = '0; pix_in.blue_in = '0;
		pix_in.alpha_in = '0; pix_in.lock_hue = 1'b0;
		pix_out.ready = 1'b0;
		shift_q = '0; sat_gain_q = GAIN_W'(ONE_GAIN); val_gain_q = GAIN_W'(ONE_GAIN);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Neutral tint passes through, including values above full scale
		push_pixel(16'd32768, 16'd0, 16'd1024, 11'd1024, 1'b0);
		push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1);
		drain();

		// Rotate, with extremes of every field, gray, black and hue-locked pixels
		write_reg(CFG_HUE_SHIFT, 15'(11520));
		write_reg(CFG_SAT_GAIN, 15'd2048);
		write_reg(CFG_VAL_GAIN, 15'd2048);
		push_pixel(16'd0, 16'd0, 16'd0, 11'd0, 1'b0);
		push_pixel(16'd5000, 16'd5000, 16'd5000, 11'd512, 1'b0);
		push_pixel(16'd32768, 16'd0, 16'd0, 11'd1024, 1'b0);
		push_pixel(16'd0, 16'd32768, 16'd0, 11'd1, 1'b1);
		push_pixel(16'd0, 16'd0, 16'd32768, 11'd7, 1'b0);
		push_pixel(16'hFFFF, 16'h0001, 16'h8000, 11'h7FF, 1'b0);
		push_pixel(16'd1000, 16'd0, 16'd2000, 11'd100, 1'b0);
		push_pixel(16'd2000, 16'd1999, 16'd0, 11'd100, 1'b1);
		drain();

		// Locked item with unity gains passes through despite a shift
		write_reg(CFG_HUE_SHIFT, 15'(-11520));
		write_reg(CFG_SAT_GAIN, 15'd1024);
		write_reg(CFG_VAL_GAIN, 15'd1024);
		push_pixel(16'd3000, 16'd100, 16'd9000, 11'd300, 1'b1);
		push_pixel(16'd3000, 16'd100, 16'd9000, 11'd300, 1'b0);
		push_pixel(16'd100, 16'd9000, 16'd3000, 11'd300, 1'b0);
		drain();

		// Zero gains, and raw register bits beyond the listed ranges
		write_reg(CFG_SAT_GAIN, 15'd0);
		write_reg(CFG_VAL_GAIN, 15'd0);
		push_random(4);
		drain();
		write_reg(CFG_HUE_SHIFT, 15'h7FFF);
		write_reg(CFG_SAT_GAIN, 15'h0FFF);
		write_reg(CFG_VAL_GAIN, 15'h0FFF);
		push_random(4);
		drain();
		write_reg(CFG_HUE_SHIFT, 15'h3FFF);
		write_reg(CFG_HUE_SHIFT, 15'h4000);
		push_random(4);
		drain();

		// Let the block fill up behind a stalled output
		hold_off = 300;
		push_random(60);
		drain();

		// Random phases, each with a fresh setting
		for (phase = 0; phase < 10; phase++) begin
			write_reg(CFG_HUE_SHIFT, $urandom_range(0, 3) == 0 ? 15'($urandom) :
				15'($signed($urandom_range(0, 23040)) - 11520));
			write_reg(CFG_SAT_GAIN, $urandom_range(0, 4) == 0 ? 15'd1024 :
				15'($urandom_range(0, 2048)));
			write_reg(CFG_VAL_GAIN, $urandom_range(0, 4) == 0 ? 15'd1024 :
				15'($urandom_range(0, 2048)));
			if (phase == 3) write_reg(CFG_HUE_SHIFT, 15'd0);
			push_random(130);
			drain();
		end

		stim_done = 1'b1;
		$display("Sent %0d pixels and checked %0d tinted words over 16 tint settings.",
			words_sent, words_seen);
		$display("Covered neutral, locked, gray, black, over-range and clamped cases.");
		if (errors == 0 && tinted_expect.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
